// File: hw/rtl/fspg_pkg.sv
// ----------------------------------------------------------------------------
// fspg_pkg: shared types and constants of the frame slot pool governor
// Item formats, operation and status codes, slot phases, controller states,
// register map and reset values.
// ----------------------------------------------------------------------------
package fspg_pkg;

  localparam int unsigned SLOTS_DEF  = 2;
  localparam int unsigned WINDOW_DEF = 240;

  localparam int unsigned SPEED_W = 12;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam logic [SPEED_W-1:0] MIN_SPEED_RST  = 12'd300;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 12'd500;
  localparam logic [SPEED_W-1:0] SPEED_STEP_RST = 12'd50;

  typedef enum logic [1:0] {
    REG_MIN_SPEED  = 2'd0,
    REG_MAX_SPEED  = 2'd1,
    REG_SPEED_STEP = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_RESERVE = 3'd0,
    OP_SUBMIT  = 3'd1,
    OP_ABORT   = 3'd2,
    OP_TAKE    = 3'd3,
    OP_DONE    = 3'd4,
    OP_FAIL    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FAILED  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_FREE     = 2'd0,
    PH_FILLING  = 2'd1,
    PH_QUEUED   = 2'd2,
    PH_ENCODING = 2'd3
  } phase_e;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0] operation;
    logic       slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               slot_out;
    logic [SPEED_W-1:0] speed_factor;
    logic               speed_changed;
    logic               all_idle;
    logic [1:0]         queue_depth;
  } out_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] min_speed;
    logic [SPEED_W-1:0] max_speed;
    logic [SPEED_W-1:0] speed_step;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic execute;
  } ctrl_cmd_t;

endpackage

// File: hw/rtl/fspg_ctrl.sv
// ----------------------------------------------------------------------------
// fspg_ctrl: item sequencer of the frame slot pool governor
// Takes one item, has the datapath execute it once the output register is
// free, and tracks the output valid flag.
// ----------------------------------------------------------------------------
module fspg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fspg_pkg::ctrl_cmd_t  cmd_o
);

  fspg_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fspg_pkg::CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & out_stall_i;
    in_stall_o  = 1'b1;
    cmd_o       = '0;
    case (state_q)
      fspg_pkg::CS_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = fspg_pkg::CS_EXEC;
        end
      end
      fspg_pkg::CS_EXEC: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.execute = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = fspg_pkg::CS_IDLE;
        end
      end
      default: begin
        state_d = fspg_pkg::CS_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/fspg_dp.sv
// ----------------------------------------------------------------------------
// fspg_dp: slot pool and speed governor datapath
// Holds slot phases, the order queue, the failure latch and the governor
// window; executes one item per execute command into the output register.
// ----------------------------------------------------------------------------
module fspg_dp #(
  parameter int unsigned SLOTS         = fspg_pkg::SLOTS_DEF,
  parameter int unsigned WINDOW_FRAMES = fspg_pkg::WINDOW_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fspg_pkg::ctrl_cmd_t  cmd_i,
  input  fspg_pkg::cfg_t       cfg_i,
  input  fspg_pkg::in_item_t   in_data_i,
  output fspg_pkg::out_item_t  out_data_o
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned SW    = fspg_pkg::SPEED_W;

  fspg_pkg::in_item_t  in_q;
  fspg_pkg::out_item_t out_q, out_d;

  fspg_pkg::phase_e phase_q [SLOTS];
  fspg_pkg::phase_e phase_d [SLOTS];
  logic             oq_q    [SLOTS];
  logic             oq_we;

  logic [IDX_W-1:0] rp_q, rp_d, wp_q, wp_d, rp_inc, wp_inc;
  logic [CNT_W-1:0] wait_q, wait_d, wait_inc, peak_q, peak_d, peak_new;
  logic             failed_q, failed_d, waiting_q, waiting_d;
  logic             pressure_q, pressure_d, started_q, started_d;
  logic [7:0]       window_q, window_d, wc_inc;
  logic [SW-1:0]    target_q, target_d;

  logic             s_ok, found, win_hit, go_down, gov_change, start_change;
  logic             entry, all_free;
  logic [IDX_W-1:0] s_idx, free_idx;
  logic [SW:0]      diff, sum;
  logic [SW-1:0]    nxt;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.execute) begin
      out_q <= out_d;
    end
    if (cmd_i.execute && oq_we) begin
      oq_q[wp_q] <= in_q.slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SLOTS; k++) begin
        phase_q[k] <= fspg_pkg::PH_FREE;
      end
      rp_q       <= '0;
      wp_q       <= '0;
      wait_q     <= '0;
      peak_q     <= '0;
      failed_q   <= 1'b0;
      waiting_q  <= 1'b0;
      pressure_q <= 1'b0;
      started_q  <= 1'b0;
      window_q   <= '0;
      target_q   <= '0;
    end else if (cmd_i.execute) begin
      for (int k = 0; k < SLOTS; k++) begin
        phase_q[k] <= phase_d[k];
      end
      rp_q       <= rp_d;
      wp_q       <= wp_d;
      wait_q     <= wait_d;
      peak_q     <= peak_d;
      failed_q   <= failed_d;
      waiting_q  <= waiting_d;
      pressure_q <= pressure_d;
      started_q  <= started_d;
      window_q   <= window_d;
      target_q   <= target_d;
    end
  end

  // slot lookup and pointer steps
  always_comb begin
    s_ok     = (SLOTS > 1) || (in_q.slot == 1'b0);
    s_idx    = s_ok ? IDX_W'(in_q.slot) : '0;
    found    = 1'b0;
    free_idx = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (phase_q[k] == fspg_pkg::PH_FREE) begin
        found    = 1'b1;
        free_idx = IDX_W'(k);
      end
    end
    rp_inc   = (rp_q == IDX_W'(SLOTS - 1)) ? '0 : rp_q + IDX_W'(1);
    wp_inc   = (wp_q == IDX_W'(SLOTS - 1)) ? '0 : wp_q + IDX_W'(1);
    entry    = oq_q[rp_q];
  end

  // governor step for a queued submit
  always_comb begin
    wait_inc = wait_q + CNT_W'(1);
    peak_new = (wait_inc > peak_q) ? wait_inc : peak_q;
    wc_inc   = window_q + 8'd1;
    win_hit  = (wc_inc >= 8'(WINDOW_FRAMES));
    go_down  = pressure_q || (peak_new >= CNT_W'(SLOTS));
    diff     = {1'b0, target_q} - {1'b0, cfg_i.speed_step};
    sum      = {1'b0, target_q} + {1'b0, cfg_i.speed_step};
    if (go_down) begin
      nxt = (diff[SW] || (diff[SW-1:0] < cfg_i.min_speed)) ? cfg_i.min_speed : diff[SW-1:0];
    end else if (target_q < cfg_i.max_speed) begin
      nxt = (sum > {1'b0, cfg_i.max_speed}) ? cfg_i.max_speed : sum[SW-1:0];
    end else begin
      nxt = target_q;
    end
    gov_change   = (nxt != '0) && (nxt != target_q);
    start_change = (cfg_i.min_speed != '0) && (cfg_i.min_speed != target_q);
  end

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      phase_d[k] = phase_q[k];
    end
    rp_d       = rp_q;
    wp_d       = wp_q;
    wait_d     = wait_q;
    peak_d     = peak_q;
    failed_d   = failed_q;
    waiting_d  = waiting_q;
    pressure_d = pressure_q;
    started_d  = started_q;
    window_d   = window_q;
    target_d   = target_q;
    oq_we      = 1'b0;
    out_d      = '0;
    out_d.status = fspg_pkg::ST_OK;
    case (fspg_pkg::op_e'(in_q.operation))
      fspg_pkg::OP_RESERVE: begin
        if (failed_q) begin
          out_d.status = fspg_pkg::ST_FAILED;
        end else begin
          if (!started_q) begin
            started_d = 1'b1;
            if (start_change) begin
              target_d            = cfg_i.min_speed;
              out_d.speed_changed = 1'b1;
            end
          end
          if (!found) begin
            if (!waiting_q) begin
              waiting_d  = 1'b1;
              pressure_d = 1'b1;
            end
            out_d.status = fspg_pkg::ST_NO_FREE;
          end else begin
            waiting_d         = 1'b0;
            phase_d[free_idx] = fspg_pkg::PH_FILLING;
            out_d.slot_out    = free_idx[0];
          end
        end
      end
      fspg_pkg::OP_SUBMIT: begin
        if (!s_ok || phase_q[s_idx] != fspg_pkg::PH_FILLING) begin
          if (failed_q) begin
            out_d.status = fspg_pkg::ST_FAILED;
          end
        end else if (failed_q) begin
          phase_d[s_idx] = fspg_pkg::PH_FREE;
          out_d.status   = fspg_pkg::ST_FAILED;
        end else if (wait_q < CNT_W'(SLOTS)) begin
          phase_d[s_idx] = fspg_pkg::PH_QUEUED;
          oq_we          = 1'b1;
          wp_d           = wp_inc;
          wait_d         = wait_inc;
          peak_d         = peak_new;
          if (started_q) begin
            window_d = wc_inc;
            if (win_hit) begin
              window_d   = '0;
              pressure_d = 1'b0;
              peak_d     = '0;
              if (gov_change) begin
                target_d            = nxt;
                out_d.speed_changed = 1'b1;
              end
            end
          end
        end
      end
      fspg_pkg::OP_ABORT: begin
        if (s_ok && phase_q[s_idx] == fspg_pkg::PH_FILLING) begin
          phase_d[s_idx] = fspg_pkg::PH_FREE;
        end
      end
      fspg_pkg::OP_TAKE: begin
        if (wait_q == '0) begin
          out_d.status = fspg_pkg::ST_EMPTY;
        end else begin
          phase_d[IDX_W'(entry)] = fspg_pkg::PH_ENCODING;
          out_d.slot_out         = entry;
          rp_d                   = rp_inc;
          wait_d                 = wait_q - CNT_W'(1);
        end
      end
      fspg_pkg::OP_DONE: begin
        if (s_ok && phase_q[s_idx] == fspg_pkg::PH_ENCODING) begin
          phase_d[s_idx] = fspg_pkg::PH_FREE;
        end
      end
      fspg_pkg::OP_FAIL: begin
        if (!failed_q) begin
          failed_d = 1'b1;
          rp_d     = '0;
          wp_d     = '0;
          wait_d   = '0;
          for (int k = 0; k < SLOTS; k++) begin
            if (phase_q[k] == fspg_pkg::PH_QUEUED) begin
              phase_d[k] = fspg_pkg::PH_FREE;
            end
          end
        end
        out_d.status = fspg_pkg::ST_FAILED;
      end
      default: begin
        out_d.status = fspg_pkg::ST_OK;
      end
    endcase
    all_free = 1'b1;
    for (int k = 0; k < SLOTS; k++) begin
      if (phase_d[k] != fspg_pkg::PH_FREE) begin
        all_free = 1'b0;
      end
    end
    out_d.speed_factor = target_d;
    out_d.all_idle     = all_free && (wait_d == '0);
    out_d.queue_depth  = 2'(wait_d);
  end

  assign out_data_o = out_q;

endmodule

// File: hw/rtl/frame_slot_pool_rate_governor.sv
// ----------------------------------------------------------------------------
// frame_slot_pool_rate_governor: frame slot pool with adaptive speed governor
// Tracks producer/consumer frame slots through an ordered queue and steps a
// speed target once per window of submitted frames.
//
// Usage:
//   Input channel (in_valid_i, in_stall_o, in_data_i) carries one operation
//   per item: reserve, submit, abort, take, done or fail, with a slot index.
//   Output channel (out_valid_o, out_stall_i, out_data_o) returns exactly one
//   result item per input item, in order: status, granted or taken slot,
//   speed target, change flag, idle flag and queue depth.
//   The sequencer takes an item, then executes it into the output register;
//   it takes no new item until the current one has been executed.
//   A finished result waits in the output register while the next item is
//   taken; execution holds while that register is still full and stalled.
//   Registers min_speed, max_speed and speed_step sit on the APB port at
//   byte addresses 0, 4 and 8; write them only while the block is idle.
//   Reset: all slots free, queue empty, failure cleared, governor stopped
//   with speed 0, registers back to 300, 500 and 50.
// ----------------------------------------------------------------------------
module frame_slot_pool_rate_governor #(
  parameter int unsigned SLOTS         = fspg_pkg::SLOTS_DEF,
  parameter int unsigned WINDOW_FRAMES = fspg_pkg::WINDOW_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  fspg_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output fspg_pkg::out_item_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fspg_pkg::ADDR_W-1:0]   paddr,
  input  logic [fspg_pkg::DATA_W-1:0]   pwdata,
  output logic [fspg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  fspg_pkg::cfg_t      cfg_q;
  fspg_pkg::ctrl_cmd_t cmd;
  fspg_pkg::reg_idx_e  reg_idx;
  logic                cfg_we;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign reg_idx = fspg_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_speed  <= fspg_pkg::MIN_SPEED_RST;
      cfg_q.max_speed  <= fspg_pkg::MAX_SPEED_RST;
      cfg_q.speed_step <= fspg_pkg::SPEED_STEP_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        fspg_pkg::REG_MIN_SPEED:  cfg_q.min_speed  <= pwdata[fspg_pkg::SPEED_W-1:0];
        fspg_pkg::REG_MAX_SPEED:  cfg_q.max_speed  <= pwdata[fspg_pkg::SPEED_W-1:0];
        fspg_pkg::REG_SPEED_STEP: cfg_q.speed_step <= pwdata[fspg_pkg::SPEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fspg_pkg::REG_MIN_SPEED:  prdata = fspg_pkg::DATA_W'(cfg_q.min_speed);
      fspg_pkg::REG_MAX_SPEED:  prdata = fspg_pkg::DATA_W'(cfg_q.max_speed);
      fspg_pkg::REG_SPEED_STEP: prdata = fspg_pkg::DATA_W'(cfg_q.speed_step);
      default:                  prdata = '0;
    endcase
  end

  fspg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  fspg_dp #(
    .SLOTS         (SLOTS),
    .WINDOW_FRAMES (WINDOW_FRAMES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg_q),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

// File: dv/frame_slot_pool_rate_governor_tb.sv
// ----------------------------------------------------------------------------
// frame_slot_pool_rate_governor_tb: self-checking bench for the slot pool
// Drives reserve/submit/abort/take/done/fail items through the input
// channel and checks each result against a cycle-free model of the slot
// phases, the order queue and the speed governor, or a typed script row.
// A short scripted opening is followed by random traffic under several
// register settings, then by a scripted failure and random items in the
// failed state. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module frame_slot_pool_rate_governor_tb;

  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int OPENING_ROWS = 20;
  localparam int SCRIPT_ROWS  = 32;

  typedef enum {SERIAL_FLOW, BUSY_FLOW, ANY_FLOW} traffic_e;

  typedef struct {
    logic [2:0]                   op;
    logic                         slot;
    bit                           typed;
    fspg_pkg::status_e            st;
    logic                         so;
    logic [fspg_pkg::SPEED_W-1:0] spd;
    logic                         chg;
    logic                         idle;
    logic [1:0]                   dep;
  } row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  fspg_pkg::in_item_t            in_data_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  fspg_pkg::out_item_t           out_data_o;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [fspg_pkg::ADDR_W-1:0]   paddr = '0;
  logic [fspg_pkg::DATA_W-1:0]   pwdata = '0;
  logic [fspg_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  frame_slot_pool_rate_governor dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  fspg_pkg::phase_e             slot_ph [fspg_pkg::SLOTS_DEF];
  logic                         order_q [fspg_pkg::SLOTS_DEF];
  logic                         rd_pos, wr_pos;
  logic [1:0]                   q_depth;
  logic                         has_failed, prod_waiting, pressure, gov_started;
  logic [7:0]                   win_cnt;
  logic [1:0]                   peak;
  logic [fspg_pkg::SPEED_W-1:0] speed;
  fspg_pkg::cfg_t               rates;
  int                           window_ticks = 0;

  fspg_pkg::out_item_t due_results[$];
  int                  mismatch_cnt = 0;
  bit                  calm = 1'b0;
  int                  stall_left = 0;

  row_t script [SCRIPT_ROWS] = '{
    '{fspg_pkg::OP_TAKE, 1'b0, 1'b1, fspg_pkg::ST_EMPTY, 1'b0, 12'd0, 1'b0, 1'b1, 2'd0},
    '{OP_RSVD7, 1'b1, 1'b1, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b1, 2'd0},
    '{fspg_pkg::OP_SUBMIT, 1'b1, 1'b1, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b1, 2'd0},
    '{fspg_pkg::OP_DONE, 1'b0, 1'b1, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b1, 2'd0},
    '{fspg_pkg::OP_ABORT, 1'b1, 1'b1, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b1, 2'd0},
    '{fspg_pkg::OP_RESERVE, 1'b0, 1'b1, fspg_pkg::ST_OK, 1'b0,
      fspg_pkg::MIN_SPEED_RST, 1'b1, 1'b0, 2'd0},
    '{fspg_pkg::OP_RESERVE, 1'b0, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_RESERVE, 1'b0, 1'b1, fspg_pkg::ST_NO_FREE, 1'b0,
      fspg_pkg::MIN_SPEED_RST, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_RESERVE, 1'b1, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_ABORT, 1'b1, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_SUBMIT, 1'b0, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_RESERVE, 1'b0, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_SUBMIT, 1'b1, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_SUBMIT, 1'b1, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_TAKE, 1'b1, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_TAKE, 1'b0, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_TAKE, 1'b0, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_DONE, 1'b1, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_DONE, 1'b0, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{OP_RSVD6, 1'b0, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_RESERVE, 1'b0, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_RESERVE, 1'b1, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_FAIL, 1'b0, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_FAIL, 1'b1, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_SUBMIT, 1'b0, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_SUBMIT, 1'b1, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_ABORT, 1'b0, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_ABORT, 1'b1, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_TAKE, 1'b0, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_DONE, 1'b0, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_DONE, 1'b1, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0},
    '{fspg_pkg::OP_RESERVE, 1'b1, 1'b0, fspg_pkg::ST_OK, 1'b0, 12'd0, 1'b0, 1'b0, 2'd0}
  };

  function automatic void reset_pool();
    for (int i = 0; i < fspg_pkg::SLOTS_DEF; i++) begin
      slot_ph[i] = fspg_pkg::PH_FREE;
      order_q[i] = 1'b0;
    end
    rd_pos = 1'b0;
    wr_pos = 1'b0;
    q_depth = '0;
    has_failed = 1'b0;
    prod_waiting = 1'b0;
    pressure = 1'b0;
    gov_started = 1'b0;
    win_cnt = '0;
    peak = '0;
    speed = '0;
    rates = '{fspg_pkg::MIN_SPEED_RST, fspg_pkg::MAX_SPEED_RST, fspg_pkg::SPEED_STEP_RST};
  endfunction

  function automatic logic load_speed(int nxt);
    if (nxt <= 0 || nxt == int'(speed)) return 1'b0;
    speed = fspg_pkg::SPEED_W'(nxt);
    return 1'b1;
  endfunction

  function automatic logic governor_step();
    int cur, nxt, lo, hi, st;
    if (!gov_started) return 1'b0;
    win_cnt = win_cnt + 8'd1;
    if (win_cnt < 8'(fspg_pkg::WINDOW_DEF)) return 1'b0;
    cur = int'(speed);
    lo = int'(rates.min_speed);
    hi = int'(rates.max_speed);
    st = int'(rates.speed_step);
    nxt = cur;
    if (pressure || peak >= 2'(fspg_pkg::SLOTS_DEF)) begin
      nxt = cur - st;
      if (nxt < lo) nxt = lo;
    end else if (cur < hi) begin
      nxt = cur + st;
      if (nxt > hi) nxt = hi;
    end
    win_cnt = '0;
    pressure = 1'b0;
    peak = '0;
    window_ticks++;
    return load_speed(nxt);
  endfunction

  function automatic fspg_pkg::out_item_t pool_step(fspg_pkg::in_item_t it);
    fspg_pkg::out_item_t r;
    logic                s;
    logic                g;
    bit                  found;
    bit                  idle;
    r = '0;
    r.status = fspg_pkg::ST_OK;
    s = it.slot;
    case (it.operation)
      fspg_pkg::OP_RESERVE: begin
        if (has_failed) begin
          r.status = fspg_pkg::ST_FAILED;
        end else begin
          if (!gov_started) begin
            gov_started = 1'b1;
            r.speed_changed = load_speed(int'(rates.min_speed));
          end
          found = 1'b0;
          g = 1'b0;
          for (int i = 0; i < fspg_pkg::SLOTS_DEF; i++) begin
            if (!found && slot_ph[i] == fspg_pkg::PH_FREE) begin
              found = 1'b1;
              g = i[0];
            end
          end
          if (!found) begin
            if (!prod_waiting) begin
              prod_waiting = 1'b1;
              pressure = 1'b1;
            end
            r.status = fspg_pkg::ST_NO_FREE;
          end else begin
            prod_waiting = 1'b0;
            slot_ph[g] = fspg_pkg::PH_FILLING;
            r.slot_out = g;
          end
        end
      end
      fspg_pkg::OP_SUBMIT: begin
        if (slot_ph[s] != fspg_pkg::PH_FILLING) begin
          if (has_failed) r.status = fspg_pkg::ST_FAILED;
        end else if (has_failed) begin
          slot_ph[s] = fspg_pkg::PH_FREE;
          r.status = fspg_pkg::ST_FAILED;
        end else if (q_depth < 2'(fspg_pkg::SLOTS_DEF)) begin
          slot_ph[s] = fspg_pkg::PH_QUEUED;
          order_q[wr_pos] = s;
          wr_pos = wr_pos + 1'b1;
          q_depth = q_depth + 2'd1;
          if (q_depth > peak) peak = q_depth;
          r.speed_changed = governor_step();
        end
      end
      fspg_pkg::OP_ABORT: begin
        if (slot_ph[s] == fspg_pkg::PH_FILLING) slot_ph[s] = fspg_pkg::PH_FREE;
      end
      fspg_pkg::OP_TAKE: begin
        if (q_depth == '0) begin
          r.status = fspg_pkg::ST_EMPTY;
        end else begin
          g = order_q[rd_pos];
          rd_pos = rd_pos + 1'b1;
          q_depth = q_depth - 2'd1;
          slot_ph[g] = fspg_pkg::PH_ENCODING;
          r.slot_out = g;
        end
      end
      fspg_pkg::OP_DONE: begin
        if (slot_ph[s] == fspg_pkg::PH_ENCODING) slot_ph[s] = fspg_pkg::PH_FREE;
      end
      fspg_pkg::OP_FAIL: begin
        if (!has_failed) begin
          has_failed = 1'b1;
          rd_pos = 1'b0;
          wr_pos = 1'b0;
          q_depth = '0;
          for (int i = 0; i < fspg_pkg::SLOTS_DEF; i++)
            if (slot_ph[i] == fspg_pkg::PH_QUEUED) slot_ph[i] = fspg_pkg::PH_FREE;
        end
        r.status = fspg_pkg::ST_FAILED;
      end
      default: ;
    endcase
    idle = (q_depth == '0);
    for (int i = 0; i < fspg_pkg::SLOTS_DEF; i++)
      if (slot_ph[i] != fspg_pkg::PH_FREE) idle = 1'b0;
    r.speed_factor = speed;
    r.all_idle = idle;
    r.queue_depth = q_depth;
    return r;
  endfunction

  function automatic logic slot_in(fspg_pkg::phase_e ph, logic pref);
    return (slot_ph[pref] == ph) ? pref : ~pref;
  endfunction

  function automatic bit any_in(fspg_pkg::phase_e ph);
    return slot_ph[0] == ph || slot_ph[1] == ph;
  endfunction

  function automatic fspg_pkg::in_item_t next_item(traffic_e mode);
    fspg_pkg::in_item_t it;
    int                 roll;
    it.slot = 1'($urandom_range(0, 1));
    it.operation = OP_RSVD6;
    case (mode)
      SERIAL_FLOW: begin
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 4))
            0: it.operation = fspg_pkg::OP_ABORT;
            1: it.operation = fspg_pkg::OP_TAKE;
            2: it.operation = fspg_pkg::OP_DONE;
            3: it.operation = OP_RSVD6;
            default: it.operation = OP_RSVD7;
          endcase
        end else if (q_depth != '0) begin
          it.operation = fspg_pkg::OP_TAKE;
        end else if (any_in(fspg_pkg::PH_ENCODING)) begin
          it.operation = fspg_pkg::OP_DONE;
          it.slot = slot_in(fspg_pkg::PH_ENCODING, it.slot);
        end else if (any_in(fspg_pkg::PH_FILLING)) begin
          it.operation = fspg_pkg::OP_SUBMIT;
          it.slot = slot_in(fspg_pkg::PH_FILLING, it.slot);
        end else begin
          it.operation = fspg_pkg::OP_RESERVE;
        end
      end
      BUSY_FLOW: begin
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
          it.operation = fspg_pkg::OP_RESERVE;
        end else if (roll < 50) begin
          it.operation = fspg_pkg::OP_SUBMIT;
          it.slot = slot_in(fspg_pkg::PH_FILLING, it.slot);
        end else if (roll < 70) begin
          it.operation = fspg_pkg::OP_TAKE;
        end else if (roll < 90) begin
          it.operation = fspg_pkg::OP_DONE;
          it.slot = slot_in(fspg_pkg::PH_ENCODING, it.slot);
        end else begin
          it.operation = 3'($urandom_range(fspg_pkg::OP_ABORT, OP_RSVD6));
          if (it.operation == fspg_pkg::OP_FAIL) it.operation = OP_RSVD7;
        end
      end
      default: it.operation = 3'($urandom_range(fspg_pkg::OP_RESERVE, OP_RSVD7));
    endcase
    return it;
  endfunction

  function automatic void flag_field(string name, logic [fspg_pkg::SPEED_W-1:0] want,
                                     logic [fspg_pkg::SPEED_W-1:0] got);
    mismatch_cnt++;
    $error("%s: expected %0d, got %0d", name, want, got);
  endfunction

  function automatic void check_result(fspg_pkg::out_item_t got);
    fspg_pkg::out_item_t want;
    if (due_results.size() == 0) begin
      mismatch_cnt++;
      $error("result with no item pending");
      return;
    end
    want = due_results.pop_front();
    if (got.status !== want.status)
      flag_field("status", 12'(want.status), 12'(got.status));
    if (got.slot_out !== want.slot_out)
      flag_field("slot_out", 12'(want.slot_out), 12'(got.slot_out));
    if (got.speed_factor !== want.speed_factor)
      flag_field("speed_factor", want.speed_factor, got.speed_factor);
    if (got.speed_changed !== want.speed_changed)
      flag_field("speed_changed", 12'(want.speed_changed), 12'(got.speed_changed));
    if (got.all_idle !== want.all_idle)
      flag_field("all_idle", 12'(want.all_idle), 12'(got.all_idle));
    if (got.queue_depth !== want.queue_depth)
      flag_field("queue_depth", 12'(want.queue_depth), 12'(got.queue_depth));
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_data_o);
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic deliver(fspg_pkg::in_item_t it, bit typed, fspg_pkg::out_item_t typed_res);
    fspg_pkg::out_item_t model_res;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    model_res = pool_step(it);
    due_results.push_back(typed ? typed_res : model_res);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_check(fspg_pkg::reg_idx_e idx, logic [fspg_pkg::SPEED_W-1:0] want);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[fspg_pkg::SPEED_W-1:0] !== want)
      flag_field("prdata", want, prdata[fspg_pkg::SPEED_W-1:0]);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_write(fspg_pkg::reg_idx_e idx, logic [fspg_pkg::SPEED_W-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= fspg_pkg::DATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      fspg_pkg::REG_MIN_SPEED:  rates.min_speed = val;
      fspg_pkg::REG_MAX_SPEED:  rates.max_speed = val;
      fspg_pkg::REG_SPEED_STEP: rates.speed_step = val;
      default: ;
    endcase
    apb_check(idx, val);
  endtask

  task automatic set_rates(logic [fspg_pkg::SPEED_W-1:0] lo, logic [fspg_pkg::SPEED_W-1:0] hi,
                           logic [fspg_pkg::SPEED_W-1:0] st);
    settle();
    apb_write(fspg_pkg::REG_MIN_SPEED, lo);
    apb_write(fspg_pkg::REG_MAX_SPEED, hi);
    apb_write(fspg_pkg::REG_SPEED_STEP, st);
  endtask

  task automatic play_rows(int first, int last);
    fspg_pkg::out_item_t typed_res;
    fspg_pkg::in_item_t  it;
    for (int k = first; k < last; k++) begin
      typed_res = '{status: script[k].st, slot_out: script[k].so,
                    speed_factor: script[k].spd, speed_changed: script[k].chg,
                    all_idle: script[k].idle, queue_depth: script[k].dep};
      it = '{operation: script[k].op, slot: script[k].slot};
      deliver(it, script[k].typed, typed_res);
    end
  endtask

  // run n items, or with n of zero until the governor closes a window
  task automatic run_traffic(traffic_e mode, int n);
    int start;
    start = window_ticks;
    for (int k = 0; (n != 0) ? (k < n) : (window_ticks == start); k++) begin
      if ($urandom_range(0, 249) == 0) settle();
      deliver(next_item(mode), 1'b0, '0);
    end
  endtask

  initial begin
    reset_pool();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_check(fspg_pkg::REG_MIN_SPEED, fspg_pkg::MIN_SPEED_RST);
    apb_check(fspg_pkg::REG_MAX_SPEED, fspg_pkg::MAX_SPEED_RST);
    apb_check(fspg_pkg::REG_SPEED_STEP, fspg_pkg::SPEED_STEP_RST);
    play_rows(0, OPENING_ROWS);
    run_traffic(BUSY_FLOW, 160);
    set_rates(12'd1, 12'd4095, 12'd4095);
    run_traffic(SERIAL_FLOW, 80);
    set_rates(12'd1, 12'd2000, 12'd4095);
    run_traffic(BUSY_FLOW, 80);
    set_rates(12'd4095, 12'd1, 12'd0);
    run_traffic(BUSY_FLOW, 100);
    play_rows(OPENING_ROWS, SCRIPT_ROWS);
    calm = 1'b1;
    run_traffic(ANY_FLOW, 100);
    in_valid_i <= 1'b0;
    for (int n = 0; n < 4000 && due_results.size() != 0; n++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (due_results.size() != 0) begin
      mismatch_cnt++;
      $error("%0d results never arrived", due_results.size());
    end
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
